@@ hw/rtl/ght_pkg.sv @@
// Shared types and constants for the generational handle table.
package ght_pkg;

   localparam int GHT_SLOTS        = 64;
   localparam int GHT_SEED_BITS    = 16;
   localparam int GHT_PAYLOAD_BITS = 32;

   typedef enum logic [1:0] {
      CMD_BIND    = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_LOOKUP  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_STALE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // Control part of the token that walks the cell chain.
   typedef struct packed {
      logic       valid;
      logic       done;
      cmd_type    cmd;
      status_type status;
   } tok_ctrl_type;

endpackage

@@ hw/rtl/ght_cell.sv @@
// One slot of the handle table: slot state plus one token stage of the chain.
module ght_cell import ght_pkg::*; #(
   parameter int IDX_BITS     = $clog2(GHT_SLOTS),
   parameter int SEED_BITS    = GHT_SEED_BITS,
   parameter int PAYLOAD_BITS = GHT_PAYLOAD_BITS,
   parameter int CELL_INDEX   = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tok_ctrl_type            up_ctrl,
   input  logic [IDX_BITS-1:0]     up_idx,
   input  logic [SEED_BITS-1:0]    up_seed,
   input  logic [PAYLOAD_BITS-1:0] up_payload,
   input  logic [IDX_BITS-1:0]     up_rslot,
   input  logic [SEED_BITS-1:0]    up_rseed,
   input  logic [PAYLOAD_BITS-1:0] up_rpayload,
   output tok_ctrl_type            dn_ctrl,
   output logic [IDX_BITS-1:0]     dn_idx,
   output logic [SEED_BITS-1:0]    dn_seed,
   output logic [PAYLOAD_BITS-1:0] dn_payload,
   output logic [IDX_BITS-1:0]     dn_rslot,
   output logic [SEED_BITS-1:0]    dn_rseed,
   output logic [PAYLOAD_BITS-1:0] dn_rpayload
);

   localparam logic [IDX_BITS-1:0] MY_INDEX = IDX_BITS'(CELL_INDEX);

   logic                    slot_used_ff,     slot_used_in;
   logic [SEED_BITS-1:0]    slot_seed_ff,     slot_seed_in;
   logic [PAYLOAD_BITS-1:0] slot_payload_ff,  slot_payload_in;

   tok_ctrl_type            tok_ctrl_ff,      tok_ctrl_in;
   logic [IDX_BITS-1:0]     tok_idx_ff,       tok_idx_in;
   logic [SEED_BITS-1:0]    tok_seed_ff,      tok_seed_in;
   logic [PAYLOAD_BITS-1:0] tok_payload_ff,   tok_payload_in;
   logic [IDX_BITS-1:0]     tok_rslot_ff,     tok_rslot_in;
   logic [SEED_BITS-1:0]    tok_rseed_ff,     tok_rseed_in;
   logic [PAYLOAD_BITS-1:0] tok_rpayload_ff,  tok_rpayload_in;

   logic                    live;
   logic                    hit;
   logic [SEED_BITS-1:0]    seed_next;

   always_comb begin
      live      = up_ctrl.valid & ~up_ctrl.done;
      hit       = live & (up_idx == MY_INDEX);
      seed_next = SEED_BITS'(slot_seed_ff + 1'b1);

      slot_used_in    = slot_used_ff;
      slot_seed_in    = slot_seed_ff;
      slot_payload_in = slot_payload_ff;

      tok_ctrl_in     = up_ctrl;
      tok_idx_in      = up_idx;
      tok_seed_in     = up_seed;
      tok_payload_in  = up_payload;
      tok_rslot_in    = up_rslot;
      tok_rseed_in    = up_rseed;
      tok_rpayload_in = up_rpayload;

      if (live && up_ctrl.cmd == CMD_BIND && !slot_used_ff) begin
         slot_used_in       = 1'b1;
         slot_payload_in    = up_payload;
         tok_ctrl_in.done   = 1'b1;
         tok_ctrl_in.status = STAT_OK;
         tok_rslot_in       = MY_INDEX;
         tok_rseed_in       = slot_seed_ff;
         tok_rpayload_in    = '0;
      end else if (hit && up_ctrl.cmd == CMD_RELEASE) begin
         slot_used_in       = 1'b0;
         slot_seed_in       = seed_next;
         tok_ctrl_in.done   = 1'b1;
         tok_ctrl_in.status = STAT_OK;
         tok_rslot_in       = up_idx;
         tok_rseed_in       = seed_next;
         tok_rpayload_in    = '0;
      end else if (hit && up_ctrl.cmd == CMD_LOOKUP) begin
         tok_ctrl_in.done = 1'b1;
         tok_rslot_in     = up_idx;
         tok_rseed_in     = slot_seed_ff;
         if (slot_used_ff && slot_seed_ff == up_seed) begin
            tok_ctrl_in.status = STAT_OK;
            tok_rpayload_in    = slot_payload_ff;
         end else begin
            tok_ctrl_in.status = STAT_STALE;
            tok_rpayload_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_used_ff <= 1'b0;
         slot_seed_ff <= '0;
         tok_ctrl_ff  <= '0;
      end else begin
         slot_used_ff <= slot_used_in;
         slot_seed_ff <= slot_seed_in;
         tok_ctrl_ff  <= tok_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_payload_ff <= slot_payload_in;
      tok_idx_ff      <= tok_idx_in;
      tok_seed_ff     <= tok_seed_in;
      tok_payload_ff  <= tok_payload_in;
      tok_rslot_ff    <= tok_rslot_in;
      tok_rseed_ff    <= tok_rseed_in;
      tok_rpayload_ff <= tok_rpayload_in;
   end

   assign dn_ctrl     = tok_ctrl_ff;
   assign dn_idx      = tok_idx_ff;
   assign dn_seed     = tok_seed_ff;
   assign dn_payload  = tok_payload_ff;
   assign dn_rslot    = tok_rslot_ff;
   assign dn_rseed    = tok_rseed_ff;
   assign dn_rpayload = tok_rpayload_ff;

endmodule

@@ hw/rtl/generational_handle_table.sv @@
// Generational handle table: a command token walks a chain of SLOTS slot cells.
// The result transfer comes once the token has passed the register of every cell in the
// chain; rsp_valid marks the result.
// Only one command is in the chain at a time; busy drops combinationally in the result
// cycle, so the next start can be taken in that cycle. The receiver cannot stall.
// Reset clears all used marks, seeds and the chain at once; payloads are not reset.
module generational_handle_table import ght_pkg::*; #(
   parameter int SLOTS        = GHT_SLOTS,
   parameter int SEED_BITS    = GHT_SEED_BITS,
   parameter int PAYLOAD_BITS = GHT_PAYLOAD_BITS,
   localparam int IDX_BITS    = $clog2(SLOTS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_command,
   input  logic [IDX_BITS-1:0]     req_slot_index,
   input  logic [SEED_BITS-1:0]    req_seed_in,
   input  logic [PAYLOAD_BITS-1:0] req_payload_in,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic [IDX_BITS-1:0]     rsp_slot_out,
   output logic [SEED_BITS-1:0]    rsp_seed_out,
   output logic [PAYLOAD_BITS-1:0] rsp_payload_out
);

   tok_ctrl_type            ctrl_w     [SLOTS+1];
   logic [IDX_BITS-1:0]     idx_w      [SLOTS+1];
   logic [SEED_BITS-1:0]    seed_w     [SLOTS+1];
   logic [PAYLOAD_BITS-1:0] payload_w  [SLOTS+1];
   logic [IDX_BITS-1:0]     rslot_w    [SLOTS+1];
   logic [SEED_BITS-1:0]    rseed_w    [SLOTS+1];
   logic [PAYLOAD_BITS-1:0] rpayload_w [SLOTS+1];

   logic             busy_ff, busy_in;
   logic             accept;
   logic             unknown_cmd;
   logic             out_of_range;
   logic             reject;
   logic             bind_full;
   logic [SLOTS-1:0] valid_vec;

   assign accept       = start & ~busy;
   assign unknown_cmd  = (req_command != CMD_BIND) && (req_command != CMD_RELEASE)
                         && (req_command != CMD_LOOKUP);
   assign out_of_range = {1'b0, req_slot_index} >= (IDX_BITS+1)'(SLOTS);
   assign reject       = unknown_cmd | ((req_command != CMD_BIND) & out_of_range);

   assign ctrl_w[0] = '{valid:  accept,
                        done:   reject,
                        cmd:    cmd_type'(req_command),
                        status: (reject ? STAT_STALE : STAT_OK)};

   assign idx_w[0]      = req_slot_index;
   assign seed_w[0]     = req_seed_in;
   assign payload_w[0]  = req_payload_in;
   assign rslot_w[0]    = req_slot_index;
   assign rseed_w[0]    = '0;
   assign rpayload_w[0] = '0;

   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      ght_cell #(
         .IDX_BITS     (IDX_BITS),
         .SEED_BITS    (SEED_BITS),
         .PAYLOAD_BITS (PAYLOAD_BITS),
         .CELL_INDEX   (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .up_ctrl     (ctrl_w[k]),
         .up_idx      (idx_w[k]),
         .up_seed     (seed_w[k]),
         .up_payload  (payload_w[k]),
         .up_rslot    (rslot_w[k]),
         .up_rseed    (rseed_w[k]),
         .up_rpayload (rpayload_w[k]),
         .dn_ctrl     (ctrl_w[k+1]),
         .dn_idx      (idx_w[k+1]),
         .dn_seed     (seed_w[k+1]),
         .dn_payload  (payload_w[k+1]),
         .dn_rslot    (rslot_w[k+1]),
         .dn_rseed    (rseed_w[k+1]),
         .dn_rpayload (rpayload_w[k+1])
      );
      assign valid_vec[k] = ctrl_w[k+1].valid;
   end

   // a bind that reaches the end unclaimed found no free slot
   assign bind_full       = ~ctrl_w[SLOTS].done;
   assign rsp_valid       = ctrl_w[SLOTS].valid;
   assign rsp_status      = bind_full ? STAT_FULL : ctrl_w[SLOTS].status;
   assign rsp_slot_out    = bind_full ? '0 : rslot_w[SLOTS];
   assign rsp_seed_out    = bind_full ? '0 : rseed_w[SLOTS];
   assign rsp_payload_out = bind_full ? '0 : rpayload_w[SLOTS];

   assign busy = busy_ff & ~ctrl_w[SLOTS].valid;

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (ctrl_w[SLOTS].valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(valid_vec))
      else $error("more than one token in the cell chain");

   a_busy_tracks_token: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (valid_vec != '0))
      else $error("busy flag disagrees with token presence");

   a_full_only_on_bind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && bind_full) |-> (ctrl_w[SLOTS].cmd == CMD_BIND))
      else $error("unresolved token that is not a bind");

endmodule
